/* design/rsa_pkg.sv */
`timescale 1ns / 1ps

package rsa_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 6;
    localparam int TICK_W    = 16;
    localparam int DIV_W     = 32;
    localparam int UPC_W     = 5;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [UPC_W-1:0]  t_upc;

    typedef enum logic [1:0] {
        CMD_FIRE   = 2'd0,
        CMD_NOFIRE = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_ACTIVE_SLOTS = 1'b0,
        CFG_SHARED_MODE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_CLAIM_INIT,
        UOP_SCAN,
        UOP_DIV_CURSOR,
        UOP_DIV_TICK,
        UOP_DIV_STEP,
        UOP_TRY_INIT,
        UOP_TRY,
        UOP_CLAIM_MARK,
        UOP_PLACE,
        UOP_IDX_REM,
        UOP_IDX_FREE,
        UOP_CLEAR,
        UOP_RES_ZERO,
        UOP_EMIT
    } t_uop;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_CMD_FREE,
        C_NO_ACTION,
        C_SINGLE,
        C_SCAN_GO,
        C_IDX_FREE,
        C_DIV_MORE,
        C_TRY_AGAIN,
        C_FIRE,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        logic cmd_free;
        logic no_action;
        logic single_mode;
        logic is_fire;
        logic scan_go;
        logic idx_free;
        logic div_more;
        logic try_again;
    } t_status;

    typedef struct packed {
        logic  placed;
        t_slot slot_index;
        logic  evicted;
        logic  cleared;
    } t_result;

    // microprogram addresses
    localparam t_upc A_WAIT     = 5'd0;
    localparam t_upc A_DISPATCH = 5'd1;
    localparam t_upc A_NOACT    = 5'd2;
    localparam t_upc A_MODE     = 5'd3;
    localparam t_upc A_CLAIM    = 5'd4;
    localparam t_upc A_SCAN     = 5'd5;
    localparam t_upc A_FOUND    = 5'd6;
    localparam t_upc A_CDIV     = 5'd7;
    localparam t_upc A_CSTEP    = 5'd8;
    localparam t_upc A_TRYINIT  = 5'd9;
    localparam t_upc A_TRY      = 5'd10;
    localparam t_upc A_MARK     = 5'd11;
    localparam t_upc A_PLACE    = 5'd12;
    localparam t_upc A_TDIV     = 5'd13;
    localparam t_upc A_TSTEP    = 5'd14;
    localparam t_upc A_TSLOT    = 5'd15;
    localparam t_upc A_CLEAR    = 5'd16;
    localparam t_upc A_FREE     = 5'd17;
    localparam t_upc A_ZERO     = 5'd18;
    localparam t_upc A_EMIT     = 5'd19;
    localparam t_upc A_EMITWAIT = 5'd20;

    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        case (a)
            A_WAIT:     w = '{UOP_NOP,        C_NO_START,  A_WAIT};
            A_DISPATCH: w = '{UOP_NOP,        C_CMD_FREE,  A_FREE};
            A_NOACT:    w = '{UOP_NOP,        C_NO_ACTION, A_ZERO};
            A_MODE:     w = '{UOP_NOP,        C_SINGLE,    A_TDIV};
            A_CLAIM:    w = '{UOP_CLAIM_INIT, C_NEVER,     A_WAIT};
            A_SCAN:     w = '{UOP_SCAN,       C_SCAN_GO,   A_SCAN};
            A_FOUND:    w = '{UOP_NOP,        C_IDX_FREE,  A_MARK};
            A_CDIV:     w = '{UOP_DIV_CURSOR, C_NEVER,     A_WAIT};
            A_CSTEP:    w = '{UOP_DIV_STEP,   C_DIV_MORE,  A_CSTEP};
            A_TRYINIT:  w = '{UOP_TRY_INIT,   C_NEVER,     A_WAIT};
            A_TRY:      w = '{UOP_TRY,        C_TRY_AGAIN, A_TRY};
            A_MARK:     w = '{UOP_CLAIM_MARK, C_NEVER,     A_WAIT};
            A_PLACE:    w = '{UOP_PLACE,      C_ALWAYS,    A_EMIT};
            A_TDIV:     w = '{UOP_DIV_TICK,   C_NEVER,     A_WAIT};
            A_TSTEP:    w = '{UOP_DIV_STEP,   C_DIV_MORE,  A_TSTEP};
            A_TSLOT:    w = '{UOP_IDX_REM,    C_FIRE,      A_PLACE};
            A_CLEAR:    w = '{UOP_CLEAR,      C_ALWAYS,    A_EMIT};
            A_FREE:     w = '{UOP_IDX_FREE,   C_ALWAYS,    A_CLEAR};
            A_ZERO:     w = '{UOP_RES_ZERO,   C_NEVER,     A_WAIT};
            A_EMIT:     w = '{UOP_EMIT,       C_OUT_FREE,  A_WAIT};
            A_EMITWAIT: w = '{UOP_NOP,        C_ALWAYS,    A_EMIT};
            default:    w = '{UOP_NOP,        C_ALWAYS,    A_WAIT};
        endcase
        return w;
    endfunction

    // saturate the slot count to 1..MAX_SLOTS
    function automatic t_cnt slot_count(input t_cnt a);
        t_cnt n;
        if (a == '0) begin
            n = t_cnt'(1);
        end else if (a > t_cnt'(MAX_SLOTS)) begin
            n = t_cnt'(MAX_SLOTS);
        end else begin
            n = a;
        end
        return n;
    endfunction

endpackage

/* design/round_slot_allocator.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_command, i_tick, i_free_index
// result    out        o_valid / i_ready    o_placed, o_slot_index, o_evicted, o_cleared
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One request at a time. A free request releases the named slot; an idle request
// returns an empty result. A shared fire scans for the first free slot; when
// every active slot is full it adds a bit-serial cursor remainder and eviction
// tries in turn. Single mode takes the slot from the same one-bit-per-cycle
// remainder loop on the halved tick. The next request is taken in the wait
// state that follows the emit step.
// Reset is synchronous, active low, and empties every slot. A stalled result
// holds in the output register; the next request is taken meanwhile and waits
// at its emit step until the register frees.

module round_slot_allocator import rsa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_command,
    input  logic signed [TICK_W-1:0] i_tick,
    input  logic [SLOT_W-1:0]        i_free_index,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_placed,
    output logic [SLOT_W-1:0]        o_slot_index,
    output logic                     o_evicted,
    output logic                     o_cleared,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CNT_W-1:0]         i_cfg_data
);

    t_cnt    r_active_slots;
    logic    r_shared_mode;
    logic    r_out_valid;
    t_result r_out;

    t_cnt    w_n;
    logic    w_start;
    logic    w_out_free;
    logic    w_idle;
    t_uop    w_op;
    t_status w_stat;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= t_cnt'(16);
            r_shared_mode  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE_SLOTS: r_active_slots <= i_cfg_data;
                CFG_SHARED_MODE:  r_shared_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_n        = slot_count(r_active_slots);
    assign w_start    = i_valid && w_idle;
    assign w_out_free = !r_out_valid || i_ready;

    rsa_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_op       (w_op),
        .o_idle     (w_idle)
    );

    rsa_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_command     (i_command),
        .i_tick        (i_tick),
        .i_free_index  (i_free_index),
        .i_slot_count  (w_n),
        .i_shared_mode (r_shared_mode),
        .i_op          (w_op),
        .o_stat        (w_stat),
        .o_res         (w_res)
    );

    // output register: load on emit, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_op == UOP_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_op == UOP_EMIT) && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_ready      = w_idle;
    assign o_valid      = r_out_valid;
    assign o_placed     = r_out.placed;
    assign o_slot_index = r_out.slot_index;
    assign o_evicted    = r_out.evicted;
    assign o_cleared    = r_out.cleared;

endmodule

/* design/rsa_sequencer.sv */
`timescale 1ns / 1ps

module rsa_sequencer import rsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_out_free,
    input  t_status i_stat,
    output t_uop    o_op,
    output logic    o_idle
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_word;
    logic   w_take;

    assign w_word = ucode(r_upc);

    always_comb begin
        case (w_word.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_START:  w_take = !i_start;
            C_CMD_FREE:  w_take = i_stat.cmd_free;
            C_NO_ACTION: w_take = i_stat.no_action;
            C_SINGLE:    w_take = i_stat.single_mode;
            C_SCAN_GO:   w_take = i_stat.scan_go;
            C_IDX_FREE:  w_take = i_stat.idx_free;
            C_DIV_MORE:  w_take = i_stat.div_more;
            C_TRY_AGAIN: w_take = i_stat.try_again;
            C_FIRE:      w_take = i_stat.is_fire;
            C_OUT_FREE:  w_take = i_out_free;
            default:     w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_upc = w_take ? w_word.target : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_op   = w_word.op;
    assign o_idle = (r_upc == A_WAIT);

endmodule

/* design/rsa_datapath.sv */
`timescale 1ns / 1ps

module rsa_datapath import rsa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [1:0]               i_command,
    input  logic signed [TICK_W-1:0] i_tick,
    input  t_slot                    i_free_index,
    input  t_cnt                     i_slot_count,
    input  logic                     i_shared_mode,
    input  t_uop                     i_op,
    output t_status                  o_stat,
    output t_result                  o_res
);

    // latched transfer
    logic [1:0]               r_cmd;
    logic signed [TICK_W-1:0] r_tick;
    t_slot                    r_free_index;

    // architectural state
    logic [MAX_SLOTS-1:0]     r_occ;
    logic [MAX_SLOTS-1:0]     r_claim;
    logic [TICK_W-1:0]        r_claim_tick;
    logic [DIV_W-1:0]         r_cursor;

    // working registers
    t_slot                    r_idx;
    t_slot                    r_rem;
    logic [DIV_W-1:0]         r_div;
    t_cnt                     r_cnt;
    t_result                  r_res;

    t_cnt                     w_n_minus1;
    logic [SLOT_W:0]          w_rem_shift;
    t_slot                    w_rem_red;
    logic signed [TICK_W-1:0] w_half;
    logic [DIV_W-1:0]         w_tick_div;
    t_slot                    w_cursor_init;
    t_slot                    w_tick_init;
    t_cnt                     w_rem_inc;
    t_slot                    w_try_next;
    logic                     w_scan_go;
    logic                     w_in_range;

    assign w_n_minus1  = i_slot_count - 1'b1;

    // one remainder bit per cycle: shift in the next dividend bit, reduce once
    assign w_rem_shift = {r_rem, r_div[DIV_W-1]};
    assign w_rem_red   = (w_rem_shift >= i_slot_count)
                         ? t_slot'(w_rem_shift - i_slot_count)
                         : t_slot'(w_rem_shift);

    assign w_half      = r_tick >>> 1;
    assign w_tick_div  = {{(DIV_W-TICK_W){w_half[TICK_W-1]}}, w_half};

    // top bit weighs +2^31 unsigned (2^31 mod n is carried as 1 mod n after
    // the remaining shifts), or -2^31 signed
    assign w_cursor_init = r_cursor[DIV_W-1]
                           ? ((i_slot_count == t_cnt'(1)) ? t_slot'(0) : t_slot'(1))
                           : t_slot'(0);
    assign w_tick_init   = w_tick_div[DIV_W-1] ? w_n_minus1[SLOT_W-1:0] : t_slot'(0);

    // keep r_rem equal to cursor mod n while the cursor advances
    assign w_rem_inc  = {1'b0, r_rem} + 1'b1;
    assign w_try_next = (r_cursor == '1) ? t_slot'(0)
                        : ((w_rem_inc == i_slot_count) ? t_slot'(0)
                                                       : w_rem_inc[SLOT_W-1:0]);

    assign w_scan_go  = r_occ[r_idx] && ({1'b0, r_idx} != w_n_minus1);
    assign w_in_range = ({1'b0, r_idx} < i_slot_count);

    always_comb begin
        o_stat.cmd_free    = (r_cmd == CMD_FREE);
        o_stat.no_action   = (r_cmd == CMD_NONE) || !r_tick[0]
                             || ((r_cmd == CMD_NOFIRE) && i_shared_mode);
        o_stat.single_mode = !i_shared_mode;
        o_stat.is_fire     = (r_cmd == CMD_FIRE);
        o_stat.scan_go     = w_scan_go;
        o_stat.idx_free    = !r_occ[r_idx];
        o_stat.div_more    = (r_cnt != t_cnt'(1));
        o_stat.try_again   = r_claim[r_rem] && (r_cnt != t_cnt'(1));
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd        <= i_command;
            r_tick       <= i_tick;
            r_free_index <= i_free_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ        <= '0;
            r_claim      <= '0;
            r_claim_tick <= '0;
            r_cursor     <= '0;
            r_idx        <= '0;
            r_rem        <= '0;
            r_div        <= '0;
            r_cnt        <= '0;
            r_res        <= '0;
        end else begin
            case (i_op)
                UOP_CLAIM_INIT: begin
                    if (r_tick != r_claim_tick) begin
                        r_claim <= '0;
                    end
                    r_claim_tick <= r_tick;
                    r_idx        <= '0;
                end
                UOP_SCAN: begin
                    if (w_scan_go) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                UOP_DIV_CURSOR: begin
                    r_div <= {r_cursor[DIV_W-2:0], 1'b0};
                    r_rem <= w_cursor_init;
                    r_cnt <= t_cnt'(DIV_W - 1);
                end
                UOP_DIV_TICK: begin
                    r_div <= {w_tick_div[DIV_W-2:0], 1'b0};
                    r_rem <= w_tick_init;
                    r_cnt <= t_cnt'(DIV_W - 1);
                end
                UOP_DIV_STEP: begin
                    r_rem <= w_rem_red;
                    r_div <= {r_div[DIV_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                end
                UOP_TRY_INIT: begin
                    r_cnt <= i_slot_count;
                end
                UOP_TRY: begin
                    r_idx    <= r_rem;
                    r_rem    <= w_try_next;
                    r_cursor <= r_cursor + 1'b1;
                    r_cnt    <= r_cnt - 1'b1;
                end
                UOP_CLAIM_MARK: begin
                    r_claim[r_idx] <= 1'b1;
                end
                UOP_PLACE: begin
                    r_res.placed     <= 1'b1;
                    r_res.slot_index <= r_idx;
                    r_res.evicted    <= r_occ[r_idx];
                    r_res.cleared    <= 1'b0;
                    r_occ[r_idx]     <= 1'b1;
                end
                UOP_IDX_REM: begin
                    r_idx <= r_rem;
                end
                UOP_IDX_FREE: begin
                    r_idx <= r_free_index;
                end
                UOP_CLEAR: begin
                    if (w_in_range && r_occ[r_idx]) begin
                        r_occ[r_idx]     <= 1'b0;
                        r_res.placed     <= 1'b0;
                        r_res.slot_index <= r_idx;
                        r_res.evicted    <= 1'b0;
                        r_res.cleared    <= 1'b1;
                    end else begin
                        r_res <= '0;
                    end
                end
                UOP_RES_ZERO: begin
                    r_res <= '0;
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_place_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == UOP_PLACE) |=> r_occ[$past(r_idx)])
        else $error("placed slot not marked occupied");

    a_try_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == UOP_TRY) |-> (r_cnt != '0))
        else $error("eviction retry with no tries left");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == UOP_DIV_STEP) |-> (r_cnt != '0))
        else $error("remainder step past last dividend bit");

    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.cleared |-> (!r_res.placed && !r_res.evicted))
        else $error("result both releases and places a slot");
`endif

endmodule

/* verif/round_slot_allocator_checker.sv */
`timescale 1ns / 1ps

module round_slot_allocator_checker import rsa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic                     i_req_ready,
    input  logic [1:0]               i_command,
    input  logic [TICK_W-1:0]        i_tick,
    input  logic [SLOT_W-1:0]        i_free_index,
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic                     i_placed,
    input  logic [SLOT_W-1:0]        i_slot_index,
    input  logic                     i_evicted,
    input  logic                     i_cleared,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CNT_W-1:0]         i_cfg_data,
    output int                       o_fail_count,
    output int                       o_outstanding
);

    // shadow of the allocator state
    logic [MAX_SLOTS-1:0] slot_busy;
    logic [MAX_SLOTS-1:0] claim_mask;
    logic [TICK_W-1:0]    claim_tick_q;
    int unsigned          cursor;
    logic [CNT_W-1:0]     cfg_count;
    logic                 cfg_shared;

    t_result              pending_results[$];
    t_result              seen;
    t_result              want;

    // floor(tick / 2) taken floor-modulo n
    function automatic int unsigned tick_home_slot(logic signed [TICK_W-1:0] tick,
                                                   int unsigned n);
        int half;
        int r;
        half = int'(tick) >>> 1;
        r = half % int'(n);
        if (r < 0) r += int'(n);
        return int'(r);
    endfunction

    function automatic t_result allocate_round(t_cmd cmd, logic [TICK_W-1:0] tick,
                                               t_slot idx);
        int unsigned n;
        int unsigned s;
        int unsigned tries;
        t_result r;
        r = '0;
        n = (cfg_count == '0) ? 1 : ((cfg_count > CNT_W'(MAX_SLOTS)) ? MAX_SLOTS : cfg_count);
        if (cmd == CMD_FREE) begin
            if (idx < n && slot_busy[idx]) begin
                slot_busy[idx] = 1'b0;
                r.cleared = 1'b1;
                r.slot_index = idx;
            end
        end else if (cmd != CMD_NONE && tick[0]) begin
            if (cmd == CMD_FIRE) begin
                if (cfg_shared) begin
                    if (tick != claim_tick_q) claim_mask = '0;
                    claim_tick_q = tick;
                    s = 0;
                    while (s < n && slot_busy[s]) s++;
                    if (s == n) begin
                        // every active slot full: walk the cursor, skip this tick's claims
                        tries = n;
                        do begin
                            s = cursor % n;
                            cursor++;
                            tries--;
                        end while (claim_mask[s] && tries != 0);
                    end
                    claim_mask[s] = 1'b1;
                end else begin
                    s = tick_home_slot(tick, n);
                end
                r.placed = 1'b1;
                r.slot_index = t_slot'(s);
                r.evicted = slot_busy[s];
                slot_busy[s] = 1'b1;
            end else if (!cfg_shared) begin
                s = tick_home_slot(tick, n);
                if (slot_busy[s]) begin
                    slot_busy[s] = 1'b0;
                    r.cleared = 1'b1;
                    r.slot_index = t_slot'(s);
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_busy = '0;
            claim_mask = '0;
            claim_tick_q = '0;
            cursor = 0;
            cfg_count = CNT_W'(16);
            cfg_shared = 1'b1;
            o_fail_count = 0;
            pending_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                seen = '{i_placed, i_slot_index, i_evicted, i_cleared};
                if (pending_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("placed", want.placed, seen.placed);
                    check_field("slot_index", want.slot_index, seen.slot_index);
                    check_field("evicted", want.evicted, seen.evicted);
                    check_field("cleared", want.cleared, seen.cleared);
                end
            end
            if (i_req_valid && i_req_ready) begin
                pending_results.push_back(allocate_round(t_cmd'(i_command), i_tick,
                                                         i_free_index));
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ACTIVE_SLOTS: cfg_count = i_cfg_data;
                    CFG_SHARED_MODE:  cfg_shared = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

/* verif/round_slot_allocator_tb.sv */
`timescale 1ns / 1ps

module round_slot_allocator_tb;
    import rsa_pkg::*;

    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [1:0]               i_command = CMD_NONE;
    logic signed [TICK_W-1:0] i_tick = '0;
    logic [SLOT_W-1:0]        i_free_index = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic                     o_placed;
    logic [SLOT_W-1:0]        o_slot_index;
    logic                     o_evicted;
    logic                     o_cleared;
    logic                     i_cfg_we = 1'b0;
    logic                     i_cfg_index = CFG_ACTIVE_SLOTS;
    logic [CNT_W-1:0]         i_cfg_data = '0;

    int fail_count;
    int outstanding;

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;

    int unsigned requests_sent = 0;
    int unsigned fires_sent = 0;
    int unsigned frees_sent = 0;
    int unsigned settings_used = 0;
    int unsigned active_count = 16;
    logic [TICK_W-1:0] tick_now = 16'd1;

    int unsigned phase_count[PHASES] = '{4, 32, 7, 63, 0, 1, 16, 32};
    bit          phase_shared[PHASES] = '{1, 1, 0, 0, 1, 0, 1, 0};

    always #10 i_clk = ~i_clk;

    round_slot_allocator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_tick       (i_tick),
        .i_free_index (i_free_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_placed     (o_placed),
        .o_slot_index (o_slot_index),
        .o_evicted    (o_evicted),
        .o_cleared    (o_cleared),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    round_slot_allocator_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_command     (i_command),
        .i_tick        (i_tick),
        .i_free_index  (i_free_index),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_placed      (o_placed),
        .i_slot_index  (o_slot_index),
        .i_evicted     (o_evicted),
        .i_cleared     (o_cleared),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // result side: random stalls, plus a long hold when the sender asks for one
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_done) begin
            hold_done <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("round_slot_allocator_tb NOT OK");
        $finish;
    end

    task automatic send_request(t_cmd cmd, logic [TICK_W-1:0] tick, t_slot idx);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < gap_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_command = cmd;
        i_tick = tick;
        i_free_index = idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        requests_sent++;
        if (cmd == CMD_FIRE) fires_sent++;
        if (cmd == CMD_FREE) frees_sent++;
    endtask

    // drop valid and let every outstanding transfer come back
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(int unsigned count, bit shared);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_index = CFG_ACTIVE_SLOTS;
        i_cfg_data = CNT_W'(count);
        @(negedge i_clk);
        i_cfg_index = CFG_SHARED_MODE;
        i_cfg_data = CNT_W'(shared);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        active_count = (count == 0) ? 1 : ((count > MAX_SLOTS) ? MAX_SLOTS : count);
        settings_used++;
    endtask

    task automatic send_random();
        int unsigned pick;
        t_cmd cmd;
        t_slot idx;
        // mostly bursts on one odd tick, advancing by two; some parity flips and jumps
        pick = $urandom_range(99);
        if (pick < 5) tick_now = TICK_W'($urandom);
        else if (pick < 30) tick_now = tick_now + 16'd2;
        else if (pick < 38) tick_now = tick_now + 16'd1;
        pick = $urandom_range(99);
        if (pick < 55) cmd = CMD_FIRE;
        else if (pick < 68) cmd = CMD_NOFIRE;
        else if (pick < 94) cmd = CMD_FREE;
        else cmd = CMD_NONE;
        if ($urandom_range(9) < 8) idx = t_slot'($urandom_range(active_count - 1));
        else idx = t_slot'($urandom_range(31));
        send_request(cmd, tick_now, idx);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // three slots, shared: fill, evict within one tick, then a new tick
        configure(3, 1'b1);
        send_request(CMD_FIRE, 16'd2, '0);
        send_request(CMD_FIRE, 16'd1, '0);
        send_request(CMD_FIRE, 16'd1, '0);
        send_request(CMD_FIRE, 16'd1, '0);
        send_request(CMD_FIRE, 16'd1, '0);
        send_request(CMD_NOFIRE, 16'd1, '0);
        send_request(CMD_FIRE, 16'd3, '0);
        send_request(CMD_FREE, 16'd4, 5'd1);
        send_request(CMD_FREE, 16'd4, 5'd1);
        send_request(CMD_FREE, 16'd5, 5'd31);
        send_request(CMD_NONE, 16'd5, 5'd2);
        send_request(CMD_FIRE, 16'h8001, '0);
        send_request(CMD_FIRE, 16'hFFFF, '0);
        send_request(CMD_FIRE, 16'h7FFF, '0);

        // zero count acts as one; rotating slot with no-fire release
        configure(0, 1'b0);
        send_request(CMD_FIRE, 16'h8001, '0);
        send_request(CMD_NOFIRE, 16'h8001, '0);
        send_request(CMD_NOFIRE, 16'h8001, '0);

        // count above the maximum saturates; negative and top ticks
        configure(63, 1'b0);
        send_request(CMD_FIRE, 16'h8003, '0);
        send_request(CMD_FIRE, 16'hFFFF, '0);
        send_request(CMD_NOFIRE, 16'hFFFF, '0);
        send_request(CMD_FIRE, 16'h7FFF, '0);
        send_request(CMD_FIRE, 16'h0000, '0);
        send_request(CMD_NOFIRE, 16'h8000, '0);
        send_request(CMD_FREE, 16'h8000, 5'd31);
        send_request(CMD_FREE, 16'h8000, 5'd0);

        for (int p = 0; p < PHASES; p++) begin
            configure(phase_count[p], phase_shared[p]);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 52; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 52; end
                default: begin gap_pct = 17; stall_pct = 17; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // back up the result side while requests keep coming
                if (p == 4 && i == 5) hold_reqs++;
                if (p == 5 && i == 25) drain();
                send_random();
            end
        end

        drain();
        $display("Sent %0d requests (%0d fires, %0d frees) over %0d slot settings,",
                 requests_sent, fires_sent, frees_sent, settings_used);
        $display("both pool modes, four traffic patterns and one long result hold-off.");
        if (fail_count == 0) begin
            $display("round_slot_allocator_tb OK");
        end else begin
            $display("round_slot_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
design/rsa_pkg.sv
design/rsa_sequencer.sv
design/rsa_datapath.sv
design/round_slot_allocator.sv
verif/round_slot_allocator_checker.sv
verif/round_slot_allocator_tb.sv
